/* hw/rtl/resource_deadlock_detector_defines.svh */
// ----------------------------------------------------------------------------
// Resource deadlock detector assertion macros
// Shared concurrent assertion forms for the deadlock detector.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_DEADLOCK_DETECTOR_DEFINES_SVH
`define RESOURCE_DEADLOCK_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/rdd_pkg.sv */
// ----------------------------------------------------------------------------
// Resource deadlock detector package
// Sizes, codes and types shared by the deadlock detector files.
// ----------------------------------------------------------------------------
package rdd_pkg;

   localparam int MAX_PROCESSES  = 16;
   localparam int MAX_RESOURCES  = 16;
   localparam int COUNT_BITS     = 16;

   localparam int PROC_BITS      = $clog2(MAX_PROCESSES);
   localparam int RES_BITS       = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int ADDR_BITS      = PROC_BITS + RES_BITS;
   localparam int TABLE_DEPTH    = 2 ** ADDR_BITS;
   localparam int AVAIL_BITS     = COUNT_BITS + PROC_BITS + 1;
   localparam int RUN_PROC_LIMIT = (MAX_PROCESSES < 16) ? MAX_PROCESSES : 16;

   localparam int CFG_BITS       = 5;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_PROCESSES = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_RESOURCES = 2'd1;

   typedef enum logic [1:0] {
      ACT_LOAD_EXIST,
      ACT_LOAD_ALLOC,
      ACT_LOAD_REQ,
      ACT_RUN
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SCAN,
      ST_CHECK,
      ST_CHECK_END,
      ST_ADD,
      ST_REPORT
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_SUM,
      OP_CHECK,
      OP_ADD
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [RES_BITS-1:0]  res;
      logic                 first;
   } tag_type;

endpackage

/* hw/rtl/rdd_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/resource_deadlock_detector.sv */
// ----------------------------------------------------------------------------
// Resource deadlock detector
// Holds existing, allocated and requested unit counts and runs the
// multiple-resource deadlock detection walk over them on command.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Beat
// req_      in         start high, busy low    action, process, resource, value
// rsp_      out        rsp_valid strobe        process_id, deadlocked, any, last
// csr_      in         csr_valid and csr_ready register index and data
//
// Busy stays low after a load beat, so loads can come every cycle while no run
// is in progress. A run totals the allocations, then over np passes skips
// finished processes, checks each unfinished one against the available counts
// and adds back the allocations of each one that finishes, then gives np result
// beats; the walk reads each table RAM through its single read port. Reset is
// synchronous; the table RAMs are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "resource_deadlock_detector_defines.svh"

module resource_deadlock_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic [3:0]                         req_process,
   input  logic [3:0]                         req_resource,
   input  logic [15:0]                        req_value,
   output logic                               rsp_valid,
   output logic [3:0]                         rsp_process_id,
   output logic                               rsp_deadlocked,
   output logic                               rsp_any_deadlock,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rdd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rdd_pkg::CFG_BITS-1:0]       csr_data
);

   import rdd_pkg::*;

   state_type                     state_ff, state_in;
   logic [CFG_BITS-1:0]           cfg_np_ff, cfg_nr_ff;
   logic [PROC_BITS-1:0]          np_last;
   logic [RES_BITS-1:0]           nr_last;
   logic [PROC_BITS-1:0]          p_ff, p_in, pass_ff, pass_in, p_adv, pass_adv;
   logic [RES_BITS-1:0]           r_ff, r_in;
   logic                          ok_ff, ok_in, ok_now;
   tag_type                       tag_ff, tag_in;
   logic [MAX_PROCESSES-1:0]      fin_ff, fin_in;
   logic [COUNT_BITS-1:0]         exist_ff [MAX_RESOURCES];
   logic signed [AVAIL_BITS-1:0]  avail_ff [MAX_RESOURCES];
   logic signed [AVAIL_BITS-1:0]  avail_in [MAX_RESOURCES];
   logic signed [AVAIL_BITS-1:0]  alloc_ext, req_ext, exist_ext;
   logic                          last_p, last_r, last_pass, done_all, chk_fail;
   logic                          accept, proc_ok, res_ok, any_dl;
   logic [PROC_BITS-1:0]          ld_proc;
   logic [RES_BITS-1:0]           ld_res;
   logic [COUNT_BITS-1:0]         ld_value;
   logic                          alloc_wr_en, req_wr_en, alloc_rd_en, req_rd_en;
   logic [ADDR_BITS-1:0]          wr_addr, rd_addr;
   logic [COUNT_BITS-1:0]         alloc_rd_data, req_rd_data;

   // Clamped last indexes of the processes and resource types in use.
   always_comb begin
      if (cfg_np_ff == '0) begin
         np_last = '0;
      end else if (int'(cfg_np_ff) > RUN_PROC_LIMIT) begin
         np_last = PROC_BITS'(RUN_PROC_LIMIT - 1);
      end else begin
         np_last = PROC_BITS'(cfg_np_ff - 1'b1);
      end
      if (cfg_nr_ff == '0) begin
         nr_last = '0;
      end else if (int'(cfg_nr_ff) > MAX_RESOURCES) begin
         nr_last = RES_BITS'(MAX_RESOURCES - 1);
      end else begin
         nr_last = RES_BITS'(cfg_nr_ff - 1'b1);
      end
   end

   assign last_p    = (p_ff == np_last);
   assign last_r    = (r_ff == nr_last);
   assign last_pass = (pass_ff == np_last);
   assign done_all  = last_p && last_pass;
   assign p_adv     = last_p ? '0 : p_ff + PROC_BITS'(1);
   assign pass_adv  = last_p ? pass_ff + PROC_BITS'(1) : pass_ff;

   assign accept   = start && !busy;
   assign res_ok   = int'(req_resource) < MAX_RESOURCES;
   assign proc_ok  = int'(req_process) < MAX_PROCESSES;
   assign ld_proc  = PROC_BITS'(req_process);
   assign ld_res   = RES_BITS'(req_resource);
   assign ld_value = COUNT_BITS'(req_value);

   assign alloc_ext = $signed({{(AVAIL_BITS-COUNT_BITS){1'b0}}, alloc_rd_data});
   assign req_ext   = $signed({{(AVAIL_BITS-COUNT_BITS){1'b0}}, req_rd_data});
   assign exist_ext = $signed({{(AVAIL_BITS-COUNT_BITS){1'b0}}, exist_ff[tag_ff.res]});
   assign chk_fail  = (tag_ff.op == OP_CHECK) && (req_ext > avail_ff[tag_ff.res]);
   assign ok_now    = ok_ff && !chk_fail;

   always_comb begin
      any_dl = 1'b0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
         if (PROC_BITS'(i) <= np_last && !fin_ff[i]) begin
            any_dl = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_action == ACT_RUN) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (last_p && last_r) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!fin_ff[p_ff]) begin
               state_in = ST_CHECK;
            end else if (done_all) begin
               state_in = ST_REPORT;
            end
         end
         ST_CHECK: begin
            if (last_r) begin
               state_in = ST_CHECK_END;
            end
         end
         ST_CHECK_END: begin
            if (ok_now) begin
               state_in = ST_ADD;
            end else if (done_all) begin
               state_in = ST_REPORT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_ADD: begin
            if (last_r) begin
               state_in = done_all ? ST_REPORT : ST_SCAN;
            end
         end
         ST_REPORT: begin
            if (last_p) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and memory port controls.
   always_comb begin
      busy             = (state_ff != ST_IDLE);
      rsp_valid        = (state_ff == ST_REPORT);
      rsp_process_id   = 4'(p_ff);
      rsp_deadlocked   = !fin_ff[p_ff];
      rsp_any_deadlock = any_dl;
      rsp_last         = last_p;
      csr_ready        = 1'b1;
      alloc_rd_en      = (state_ff == ST_SUM) || (state_ff == ST_ADD);
      req_rd_en        = (state_ff == ST_CHECK);
      rd_addr          = {p_ff, r_ff};
      wr_addr          = {ld_proc, ld_res};
      alloc_wr_en      = accept && proc_ok && res_ok && req_action == ACT_LOAD_ALLOC;
      req_wr_en        = accept && proc_ok && res_ok && req_action == ACT_LOAD_REQ;
   end

   // Walk counters, read tags and finished marks.
   always_comb begin
      p_in       = p_ff;
      r_in       = r_ff;
      pass_in    = pass_ff;
      ok_in      = ok_now;
      fin_in     = fin_ff;
      tag_in.op    = OP_NONE;
      tag_in.res   = r_ff;
      tag_in.first = (p_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            p_in    = '0;
            r_in    = '0;
            pass_in = '0;
            if (accept && req_action == ACT_RUN) begin
               fin_in = '0;
            end
         end
         ST_SUM: begin
            tag_in.op = OP_SUM;
            p_in      = p_adv;
            if (last_p) begin
               r_in = last_r ? '0 : r_ff + RES_BITS'(1);
            end
         end
         ST_SCAN: begin
            r_in = '0;
            if (fin_ff[p_ff]) begin
               p_in    = p_adv;
               pass_in = pass_adv;
            end else begin
               ok_in = 1'b1;
            end
         end
         ST_CHECK: begin
            tag_in.op = OP_CHECK;
            r_in      = last_r ? '0 : r_ff + RES_BITS'(1);
         end
         ST_CHECK_END: begin
            if (!ok_now) begin
               p_in    = p_adv;
               pass_in = pass_adv;
            end
         end
         ST_ADD: begin
            tag_in.op = OP_ADD;
            r_in      = last_r ? '0 : r_ff + RES_BITS'(1);
            if (last_r) begin
               fin_in[p_ff] = 1'b1;
               p_in         = p_adv;
               pass_in      = pass_adv;
            end
         end
         ST_REPORT: begin
            p_in = p_adv;
         end
         default: begin
            p_in = '0;
         end
      endcase
   end

   // Available counts follow the data returned by the allocation RAM.
   always_comb begin
      avail_in = avail_ff;
      unique case (tag_ff.op)
         OP_SUM: begin
            avail_in[tag_ff.res] = (tag_ff.first ? exist_ext : avail_ff[tag_ff.res])
                                   - alloc_ext;
         end
         OP_ADD: begin
            avail_in[tag_ff.res] = avail_ff[tag_ff.res] + alloc_ext;
         end
         OP_NONE, OP_CHECK: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cfg_np_ff <= CFG_BITS'(1);
         cfg_nr_ff <= CFG_BITS'(1);
         p_ff      <= '0;
         r_ff      <= '0;
         pass_ff   <= '0;
         ok_ff     <= 1'b0;
         tag_ff    <= '{op: OP_NONE, res: '0, first: 1'b0};
         fin_ff    <= '0;
         for (int j = 0; j < MAX_RESOURCES; j++) begin
            exist_ff[j] <= '0;
            avail_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         r_ff     <= r_in;
         pass_ff  <= pass_in;
         ok_ff    <= ok_in;
         tag_ff   <= tag_in;
         fin_ff   <= fin_in;
         avail_ff <= avail_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_PROCESSES) begin
               cfg_np_ff <= csr_data;
            end else if (csr_index == CSR_NUM_RESOURCES) begin
               cfg_nr_ff <= csr_data;
            end
         end
         if (accept && res_ok && req_action == ACT_LOAD_EXIST) begin
            exist_ff[ld_res] <= ld_value;
         end
      end
   end

   rdd_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_alloc_ram (
      .clock   (clock),
      .wr_en   (alloc_wr_en),
      .wr_addr (wr_addr),
      .wr_data (ld_value),
      .rd_en   (alloc_rd_en),
      .rd_addr (rd_addr),
      .rd_data (alloc_rd_data)
   );

   rdd_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_req_ram (
      .clock   (clock),
      .wr_en   (req_wr_en),
      .wr_addr (wr_addr),
      .wr_data (ld_value),
      .rd_en   (req_rd_en),
      .rd_addr (rd_addr),
      .rd_data (req_rd_data)
   );

   `RDD_ASSERT_NOW(a_rsp_only_busy, clock, reset, rsp_valid, busy)
   `RDD_ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && rsp_last, !busy)
   `RDD_ASSERT_NEXT(a_rsp_contiguous, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   `RDD_ASSERT_NEXT(a_run_goes_busy, clock, reset, accept && req_action == ACT_RUN, busy)

endmodule

/* tb/resource_deadlock_detector_tb.sv */
// ----------------------------------------------------------------------------
// Resource deadlock detector testbench
// Fills the unit tables through the command port and runs detection under
// many process and resource counts. It sends directed count extremes and
// register limits first, then random load scenarios and noise. Every result
// beat is compared with the deadlock walk that the testbench works out itself.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module resource_deadlock_detector_tb;
   import rdd_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 100;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct {
      logic [3:0] process_id;
      logic       deadlocked;
      logic       any_deadlock;
      logic       last;
   } detect_report_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   action_type                req_action;
   logic [3:0]                req_process;
   logic [3:0]                req_resource;
   logic [15:0]               req_value;
   logic                      rsp_valid;
   logic [3:0]                rsp_process_id;
   logic                      rsp_deadlocked;
   logic                      rsp_any_deadlock;
   logic                      rsp_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]       csr_data;

   logic [15:0]         exist_units [MAX_RESOURCES];
   logic [15:0]         alloc_units [MAX_PROCESSES][MAX_RESOURCES];
   logic [15:0]         req_units [MAX_PROCESSES][MAX_RESOURCES];
   logic [CFG_BITS-1:0] proc_count_reg;
   logic [CFG_BITS-1:0] res_count_reg;
   detect_report_type   expected_reports [$];
   int                  mismatch_count = 0;
   int                  items_sent = 0;
   bit                  no_gaps = 1'b0;

   resource_deadlock_detector dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_process      (req_process),
      .req_resource     (req_resource),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_process_id   (rsp_process_id),
      .rsp_deadlocked   (rsp_deadlocked),
      .rsp_any_deadlock (rsp_any_deadlock),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4 clock = ~clock;

   function automatic int clamp_count(logic [CFG_BITS-1:0] raw, int hi);
      if (raw == 0) return 1;
      if (int'(raw) > hi) return hi;
      return int'(raw);
   endfunction

   function automatic logic [15:0] draw_count(bit heavy);
      if (heavy) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 4));
   endfunction

   function automatic void predict_detection();
      longint            avail [MAX_RESOURCES];
      bit                done [MAX_PROCESSES];
      bit                fits;
      bit                any_stuck;
      longint            used;
      int                np;
      int                nr;
      detect_report_type rep;
      np = clamp_count(proc_count_reg, RUN_PROC_LIMIT);
      nr = clamp_count(res_count_reg, MAX_RESOURCES);
      for (int j = 0; j < nr; j++) begin
         used = 0;
         for (int i = 0; i < np; i++) used += longint'(alloc_units[i][j]);
         avail[j] = longint'(exist_units[j]) - used;
      end
      for (int i = 0; i < MAX_PROCESSES; i++) done[i] = 1'b0;
      for (int sweep = 0; sweep < np; sweep++) begin
         for (int i = 0; i < np; i++) begin
            if (!done[i]) begin
               fits = 1'b1;
               for (int j = 0; j < nr; j++)
                  if (longint'(req_units[i][j]) > avail[j]) fits = 1'b0;
               if (fits) begin
                  for (int j = 0; j < nr; j++) avail[j] += longint'(alloc_units[i][j]);
                  done[i] = 1'b1;
               end
            end
         end
      end
      any_stuck = 1'b0;
      for (int i = 0; i < np; i++) if (!done[i]) any_stuck = 1'b1;
      for (int i = 0; i < np; i++) begin
         rep.process_id   = 4'(i);
         rep.deadlocked   = !done[i];
         rep.any_deadlock = any_stuck;
         rep.last         = (i + 1 == np);
         expected_reports.push_back(rep);
      end
   endfunction

   function automatic void apply_item(action_type act, logic [3:0] proc, logic [3:0] res,
                                      logic [15:0] val);
      case (act)
         ACT_LOAD_EXIST: exist_units[res] = val;
         ACT_LOAD_ALLOC: alloc_units[proc][res] = val;
         ACT_LOAD_REQ:   req_units[proc][res] = val;
         default:        predict_detection();
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_reports
      detect_report_type want;
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("result beat for process %0d with none expected",
                                      rsp_process_id));
         end else begin
            want = expected_reports.pop_front();
            if (rsp_process_id !== want.process_id)
               report_mismatch($sformatf("process_id got %0d want %0d",
                                         rsp_process_id, want.process_id));
            if (rsp_deadlocked !== want.deadlocked)
               report_mismatch($sformatf("deadlocked for process %0d got %0b want %0b",
                                         want.process_id, rsp_deadlocked, want.deadlocked));
            if (rsp_any_deadlock !== want.any_deadlock)
               report_mismatch($sformatf("any_deadlock for process %0d got %0b want %0b",
                                         want.process_id, rsp_any_deadlock,
                                         want.any_deadlock));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last for process %0d got %0b want %0b",
                                         want.process_id, rsp_last, want.last));
         end
      end
   end

   task automatic send_item(action_type act, logic [3:0] proc, logic [3:0] res,
                            logic [15:0] val);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_action   <= act;
      req_process  <= proc;
      req_resource <= res;
      req_value    <= val;
      do @(posedge clock); while (busy);
      apply_item(act, proc, res, val);
      items_sent++;
   endtask

   task automatic settle_block();
      start <= 1'b0;
      do @(posedge clock); while (expected_reports.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_NUM_PROCESSES) proc_count_reg = data;
      else if (idx == CSR_NUM_RESOURCES) res_count_reg = data;
   endtask

   task automatic send_run();
      send_item(ACT_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
   endtask

   task automatic send_noise(bit heavy);
      action_type act;
      act = action_type'($urandom_range(0, 2));
      send_item(act, 4'($urandom), 4'($urandom), draw_count(heavy));
   endtask

   task automatic test_table_fill();
      for (int p = 0; p < MAX_PROCESSES; p++) begin
         for (int r = 0; r < MAX_RESOURCES; r++) begin
            send_item(ACT_LOAD_ALLOC, 4'(p), 4'(r), 16'($urandom_range(0, 3)));
            send_item(ACT_LOAD_REQ, 4'(p), 4'(r), 16'($urandom_range(0, 3)));
         end
      end
      for (int r = 0; r < MAX_RESOURCES; r++)
         send_item(ACT_LOAD_EXIST, 4'($urandom), 4'(r), 16'($urandom_range(0, 40)));
   endtask

   task automatic test_reset_settings();
      send_run();
   endtask

   task automatic test_count_extremes();
      write_register(CSR_NUM_PROCESSES, 5'd2);
      write_register(CSR_NUM_RESOURCES, 5'd2);
      send_item(ACT_LOAD_EXIST, 4'd15, 4'd0, 16'hFFFF);
      send_item(ACT_LOAD_EXIST, 4'd0, 4'd1, 16'h0000);
      send_item(ACT_LOAD_ALLOC, 4'd0, 4'd0, 16'hFFFF);
      send_item(ACT_LOAD_ALLOC, 4'd0, 4'd1, 16'h0000);
      send_item(ACT_LOAD_ALLOC, 4'd1, 4'd0, 16'h0000);
      send_item(ACT_LOAD_ALLOC, 4'd1, 4'd1, 16'h0000);
      send_item(ACT_LOAD_REQ, 4'd0, 4'd0, 16'h0000);
      send_item(ACT_LOAD_REQ, 4'd0, 4'd1, 16'h0000);
      send_item(ACT_LOAD_REQ, 4'd1, 4'd0, 16'hFFFF);
      send_item(ACT_LOAD_REQ, 4'd1, 4'd1, 16'h0000);
      send_run();
      // With nothing existing, the available count goes deeply negative.
      send_item(ACT_LOAD_EXIST, 4'd0, 4'd0, 16'h0000);
      send_run();
   endtask

   task automatic test_register_limits();
      write_register(CSR_NUM_PROCESSES, 5'd0);
      write_register(CSR_NUM_RESOURCES, 5'd31);
      send_run();
      write_register(CSR_NUM_PROCESSES, 5'd31);
      write_register(CSR_NUM_RESOURCES, 5'd0);
      send_item(ACT_LOAD_REQ, 4'd15, 4'd15, 16'hFFFF);
      send_item(ACT_LOAD_ALLOC, 4'd15, 4'd0, 16'h0001);
      send_run();
      write_register(CSR_NUM_PROCESSES, 5'd16);
      write_register(CSR_NUM_RESOURCES, 5'd16);
      send_run();
      write_register(CSR_SPARE_LOW, 5'd31);
      write_register(CSR_SPARE_HIGH, 5'd0);
      send_item(ACT_LOAD_REQ, 4'd15, 4'd15, 16'h0002);
      send_run();
      write_register(CSR_NUM_PROCESSES, 5'd1);
      write_register(CSR_NUM_RESOURCES, 5'd1);
      send_run();
   endtask

   task automatic random_scenario();
      int          np;
      int          nr;
      int          total;
      bit          heavy;
      int          ending;
      np = clamp_count(proc_count_reg, RUN_PROC_LIMIT);
      nr = clamp_count(res_count_reg, MAX_RESOURCES);
      heavy = ($urandom_range(0, 7) == 0);
      if (np * nr > 36) begin
         repeat (8)
            send_item(($urandom_range(0, 1) == 0) ? ACT_LOAD_ALLOC : ACT_LOAD_REQ,
                      4'($urandom_range(0, np - 1)), 4'($urandom_range(0, nr - 1)),
                      draw_count(heavy));
      end else begin
         for (int p = 0; p < np; p++) begin
            for (int r = 0; r < nr; r++) begin
               if ($urandom_range(0, 11) == 0) send_noise(heavy);
               send_item(ACT_LOAD_ALLOC, 4'(p), 4'(r), draw_count(heavy));
               send_item(ACT_LOAD_REQ, 4'(p), 4'(r), draw_count(heavy));
            end
         end
      end
      for (int r = 0; r < nr; r++) begin
         total = $urandom_range(0, 3);
         for (int p = 0; p < np; p++) total += int'(alloc_units[p][r]);
         if (heavy && $urandom_range(0, 1) == 0) total = $urandom_range(0, 65535);
         if (total > 65535) total = 65535;
         send_item(ACT_LOAD_EXIST, 4'($urandom), 4'(r), 16'(total));
      end
      ending = $urandom_range(0, 7);
      if (ending != 0) send_run();
      if (ending == 1) send_run();
   endtask

   task automatic test_random_phases();
      int first_item;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               write_register(CSR_NUM_PROCESSES, 5'($urandom_range(0, 31)));
               write_register(CSR_NUM_RESOURCES, 5'($urandom_range(0, 31)));
            end
            1: begin
               write_register(CSR_NUM_PROCESSES, 5'd16);
               write_register(CSR_NUM_RESOURCES, 5'($urandom_range(1, 16)));
            end
            default: begin
               write_register(CSR_NUM_PROCESSES, 5'($urandom_range(1, 6)));
               write_register(CSR_NUM_RESOURCES, 5'($urandom_range(1, 5)));
            end
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) random_scenario();
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset        <= 1'b1;
      start        <= 1'b0;
      req_action   <= ACT_LOAD_EXIST;
      req_process  <= 4'd0;
      req_resource <= 4'd0;
      req_value    <= 16'd0;
      csr_valid    <= 1'b0;
      csr_index    <= CSR_NUM_PROCESSES;
      csr_data     <= 5'd1;
      proc_count_reg = 5'd1;
      res_count_reg  = 5'd1;
      for (int r = 0; r < MAX_RESOURCES; r++) exist_units[r] = 16'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_fill();
      test_reset_settings();
      test_count_extremes();
      test_register_limits();
      test_random_phases();

      settle_block();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rdd_pkg.sv
hw/rtl/rdd_ram.sv
hw/rtl/resource_deadlock_detector.sv
tb/resource_deadlock_detector_tb.sv
